### hdl/csdc_pkg.sv
// Package with the shared types, constants and step table of the divider calculator.
package csdc_pkg;

    typedef struct packed {
        logic [31:0] freq_hz;
        logic        enable;
    } t_in;

    typedef struct packed {
        logic [7:0] reg_address;
        logic [7:0] reg_data;
        logic       last;
    } t_out;

    // Job handed from the front to the back part.
    typedef struct packed {
        logic        enable;
        logic [39:0] vco;
        logic [10:0] m;
        logic [2:0]  r;
    } t_job;

    localparam logic [31:0] FREQ_MIN = 32'd1500;
    localparam logic [31:0] FREQ_MAX = 32'd280000000;
    localparam logic [19:0] FRAC_DEN = 20'hFFFFF;
    localparam int          NSTEPS   = 36;

    localparam logic [7:0] REG_ENABLE = 8'd17;
    localparam logic [7:0] VAL_ON     = 8'h6C;
    localparam logic [7:0] VAL_OFF    = 8'h80;

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_EMIT} t_state;

    function automatic logic [31:0] step_thr(input logic [5:0] i);
        logic [31:0] v;
        begin
            unique case (i)
                6'd0: v = 32'd125000001;  6'd1: v = 32'd87600000;
                6'd2: v = 32'd68000000;   6'd3: v = 32'd55600000;
                6'd4: v = 32'd47100000;   6'd5: v = 32'd40800000;
                6'd6: v = 32'd36000000;   6'd7: v = 32'd32300000;
                6'd8: v = 32'd29200000;   6'd9: v = 32'd26700000;
                6'd10: v = 32'd24600000;  6'd11: v = 32'd22700000;
                6'd12: v = 32'd21200000;  6'd13: v = 32'd19700000;
                6'd14: v = 32'd18600000;  6'd15: v = 32'd17600000;
                6'd16: v = 32'd16300000;  6'd17: v = 32'd14700000;
                6'd18: v = 32'd13100000;  6'd19: v = 32'd11600000;
                6'd20: v = 32'd10100000;  6'd21: v = 32'd8520000;
                6'd22: v = 32'd6970000;   6'd23: v = 32'd5430000;
                6'd24: v = 32'd3880000;   6'd25: v = 32'd2340000;
                6'd26: v = 32'd797000;    6'd27: v = 32'd500000;
                6'd28: v = 32'd330000;    6'd29: v = 32'd150000;
                6'd30: v = 32'd67000;     6'd31: v = 32'd30300;
                6'd32: v = 32'd14000;     6'd33: v = 32'd7000;
                6'd34: v = 32'd3500;
                default: v = 32'd0;
            endcase
            return v;
        end
    endfunction

    function automatic logic [10:0] step_m(input logic [5:0] i);
        logic [10:0] v;
        begin
            unique case (i)
                6'd0: v = 11'd4;    6'd1: v = 11'd6;    6'd2: v = 11'd8;
                6'd3: v = 11'd10;   6'd4: v = 11'd12;   6'd5: v = 11'd14;
                6'd6: v = 11'd16;   6'd7: v = 11'd18;   6'd8: v = 11'd20;
                6'd9: v = 11'd22;   6'd10: v = 11'd24;  6'd11: v = 11'd26;
                6'd12: v = 11'd28;  6'd13: v = 11'd30;  6'd14: v = 11'd32;
                6'd15: v = 11'd34;  6'd16: v = 11'd36;  6'd17: v = 11'd40;
                6'd18: v = 11'd44;  6'd19: v = 11'd50;  6'd20: v = 11'd56;
                6'd21: v = 11'd66;  6'd22: v = 11'd78;  6'd23: v = 11'd98;
                6'd24: v = 11'd128; 6'd25: v = 11'd190; 6'd26: v = 11'd360;
                6'd27: v = 11'd800; 6'd28: v = 11'd1280; 6'd29: v = 11'd1300;
                6'd30: v = 11'd1500; 6'd31: v = 11'd1600;
                default: v = 11'd1800;
            endcase
            return v;
        end
    endfunction

    function automatic logic [2:0] step_r(input logic [5:0] i);
        logic [2:0] v;
        begin
            unique case (i)
                6'd29: v = 3'd1;
                6'd30: v = 3'd2;
                6'd31: v = 3'd3;
                6'd32: v = 3'd4;
                6'd33: v = 3'd5;
                6'd34: v = 3'd6;
                6'd35: v = 3'd7;
                default: v = 3'd0;
            endcase
            return v;
        end
    endfunction

endpackage

### hdl/csdc_front.sv
// Front part: clamps the frequency, picks M and R, and forms the VCO value.
module csdc_front
    import csdc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_in  i_in,
    input  logic i_in_valid,
    output logic o_in_ready,
    output t_job o_job,
    output logic o_job_valid,
    input  logic i_job_ready
);

    logic        r_busy, n_busy;
    logic [31:0] r_f;
    logic        r_en;
    logic [5:0]  r_idx;
    logic        r_mul;
    logic [39:0] r_prod;
    logic        r_out_valid;
    t_job        r_job;
    logic [31:0] w_clamp;
    logic        w_hit;

    assign w_clamp = (i_in.freq_hz < FREQ_MIN) ? FREQ_MIN :
                     (i_in.freq_hz > FREQ_MAX) ? FREQ_MAX : i_in.freq_hz;
    assign w_hit   = (r_f >= step_thr(r_idx)) || (r_idx == 6'(NSTEPS - 1));
    assign o_in_ready  = !r_busy && !r_out_valid;
    assign o_job       = r_job;
    assign o_job_valid = r_out_valid;

    always_comb begin
        n_busy = r_busy;
        if (i_in_valid && o_in_ready) begin
            n_busy = 1'b1;
        end else if (r_busy && r_mul) begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_mul       <= 1'b0;
        end else begin
            r_busy <= n_busy;
            if (i_in_valid && o_in_ready) begin
                r_f   <= w_clamp;
                r_en  <= i_in.enable;
                r_idx <= '0;
                r_mul <= 1'b0;
                // A disable request needs no search.
                if (!i_in.enable) begin
                    r_mul <= 1'b1;
                end
            end else if (r_busy && !r_mul) begin
                if (w_hit) begin
                    r_prod <= 40'(r_f * 32'(step_m(r_idx)));
                    r_mul  <= 1'b1;
                end else begin
                    r_idx <= r_idx + 6'd1;
                end
            end else if (r_busy && r_mul) begin
                r_job.enable <= r_en;
                r_job.m      <= step_m(r_idx);
                r_job.r      <= step_r(r_idx);
                r_job.vco    <= r_prod << step_r(r_idx);
                r_out_valid  <= 1'b1;
            end
            if (r_out_valid && i_job_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

### hdl/csdc_back.sv
// Back part: divides the VCO value by the crystal and emits the register writes.
module csdc_back
    import csdc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [25:0] i_xtal,
    input  t_job        i_job,
    input  logic        i_job_valid,
    output logic        o_job_ready,
    output t_out        o_out,
    output logic        o_out_valid,
    input  logic        i_out_ready
);

    t_state      r_state, n_state;
    t_job        r_job;
    logic [25:0] r_div;
    logic [39:0] r_quo;
    logic [26:0] r_rem;
    logic [6:0]  r_cnt;
    logic [4:0]  r_k;
    logic        r_ph;
    logic [45:0] r_num;
    logic [10:0] r_a;
    logic [26:0] w_trial;
    logic        w_ge;
    logic [26:0] w_rem_nx;
    logic [39:0] w_quo_nx;
    logic [17:0] w_p1;
    logic [17:0] w_p1r;
    logic [19:0] w_p2;
    logic [19:0] w_b;
    logic [26:0] w_bb;
    logic [6:0]  w_dd;
    logic [17:0] w_mp1;
    logic [7:0]  w_addr, w_data;
    logic        w_last;
    logic        w_fire;

    assign w_trial  = {r_rem[25:0], r_num[45]};
    assign w_ge     = (w_trial >= {1'b0, r_div});
    assign w_rem_nx = w_ge ? (w_trial - {1'b0, r_div}) : w_trial;
    assign w_quo_nx = {r_quo[38:0], w_ge};
    assign w_b     = r_quo[19:0];
    assign w_bb    = {w_b, 7'd0};
    assign w_dd    = 7'((w_bb + {7'd0, w_bb[26:20]} + 27'd1) >> 20);
    assign w_mp1   = 18'({r_job.m, 7'd0} - 18'd512);
    assign w_fire  = o_out_valid && i_out_ready;
    assign o_job_ready = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_EMIT);
    assign o_out = '{reg_address: w_addr, reg_data: w_data, last: w_last};

    assign w_p1r = 18'({r_a, 7'd0} + {11'd0, w_dd} - 18'd512);
    assign w_p2  = 20'(w_bb - 27'(28'(w_dd) * 28'(FRAC_DEN)));
    assign w_p1  = w_p1r;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_job_valid) n_state = i_job.enable ? ST_DIV : ST_EMIT;
            ST_DIV:  if (r_ph && r_cnt == 7'd0) n_state = ST_EMIT;
            ST_EMIT: if (w_fire && w_last) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_addr = 8'd0;
        w_data = 8'd0;
        w_last = 1'b0;
        if (!r_job.enable) begin
            w_addr = REG_ENABLE;
            w_data = VAL_OFF;
            w_last = 1'b1;
        end else begin
            case (r_k)
                5'd0: begin w_addr = REG_ENABLE; w_data = VAL_ON; end
                5'd1: begin w_addr = 8'd34; w_data = FRAC_DEN[15:8]; end
                5'd2: begin w_addr = 8'd35; w_data = FRAC_DEN[7:0]; end
                5'd3: begin w_addr = 8'd36; w_data = {6'd0, w_p1[17:16]}; end
                5'd4: begin w_addr = 8'd37; w_data = w_p1[15:8]; end
                5'd5: begin w_addr = 8'd38; w_data = w_p1[7:0]; end
                5'd6: begin w_addr = 8'd39; w_data = {FRAC_DEN[19:16], w_p2[19:16]}; end
                5'd7: begin w_addr = 8'd40; w_data = w_p2[15:8]; end
                5'd8: begin w_addr = 8'd41; w_data = w_p2[7:0]; end
                5'd9: begin w_addr = 8'd50; end
                5'd10: begin w_addr = 8'd51; w_data = 8'd1; end
                5'd11: begin
                    w_addr = 8'd52;
                    w_data = (r_job.m == 11'd4) ? 8'h0C
                             : {1'b0, r_job.r, 2'b00, w_mp1[17:16]};
                end
                5'd12: begin
                    w_addr = 8'd53;
                    w_data = (r_job.m == 11'd4) ? 8'd0 : w_mp1[15:8];
                end
                5'd13: begin
                    w_addr = 8'd54;
                    w_data = (r_job.m == 11'd4) ? 8'd0 : w_mp1[7:0];
                end
                5'd14: w_addr = 8'd55;
                5'd15: w_addr = 8'd56;
                default: begin w_addr = 8'd57; w_last = 1'b1; end
            endcase
        end
    end

    // Restoring division, one quotient bit per cycle; phase 0 gives a,
    // phase 1 gives b from the remainder times 0xFFFFF.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        if (r_state == ST_IDLE && i_job_valid) begin
            r_job <= i_job;
            r_div <= (i_xtal == 26'd0) ? 26'd1 : i_xtal;
            r_num <= {i_job.vco, 6'd0};
            r_rem <= '0;
            r_quo <= '0;
            r_cnt <= 7'd39;
            r_ph  <= 1'b0;
            r_k   <= '0;
        end else if (r_state == ST_DIV) begin
            if (r_cnt == 7'd0 && !r_ph) begin
                r_ph  <= 1'b1;
                r_a   <= w_quo_nx[10:0];
                r_num <= {w_rem_nx[25:0], 20'd0} - {20'd0, w_rem_nx[25:0]};
                r_rem <= '0;
                r_quo <= '0;
                r_cnt <= 7'd45;
            end else begin
                r_rem <= w_rem_nx;
                r_quo <= w_quo_nx;
                r_num <= {r_num[44:0], 1'b0};
                r_cnt <= r_cnt - 7'd1;
            end
        end else if (w_fire) begin
            r_k <= r_k + 5'd1;
        end
    end

endmodule

### hdl/clock_synth_divider_calc.sv
// Top level of the divider calculator: configuration register, front and back.
// A request first passes the front, whose step search checks one threshold per cycle,
// then, if enabled, bit-serial division in the back, followed by 17 transfers (one for
// a disable request). Front and back overlap, so the back sets the rate.
module clock_synth_divider_calc
    import csdc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [25:0] i_cfg_data,
    input  t_in         i_in,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    output t_out        o_out,
    output logic        o_out_valid,
    input  logic        i_out_ready
);

    logic [25:0] r_xtal;
    t_job        w_job;
    logic        w_job_valid, w_job_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xtal <= 26'd25000000;
        end else if (i_cfg_we) begin
            r_xtal <= i_cfg_data;
        end
    end

    csdc_front u_front (
        .i_clk, .i_rst_n, .i_in, .i_in_valid, .o_in_ready,
        .o_job(w_job), .o_job_valid(w_job_valid), .i_job_ready(w_job_ready)
    );

    csdc_back u_back (
        .i_clk, .i_rst_n, .i_xtal(r_xtal),
        .i_job(w_job), .i_job_valid(w_job_valid), .o_job_ready(w_job_ready),
        .o_out, .o_out_valid, .i_out_ready
    );

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");
    a_job_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_job_valid && !w_job_ready |=> w_job_valid)
        else $error("job dropped");

endmodule

### verif/clock_synth_divider_calc_tb.sv
// Self-checking testbench for the divider calculator with a built-in predictor.
`timescale 1ns / 100ps

module clock_synth_divider_calc_tb;
    import csdc_pkg::*;

    localparam longint CYCLE_LIMIT = 2000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [25:0] i_cfg_data;
    t_in         i_in;
    logic        i_in_valid;
    logic        o_in_ready;
    t_out        o_out;
    logic        o_out_valid;
    logic        i_out_ready;

    clock_synth_divider_calc i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out       (o_out),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready)
    );

    t_in    request_queue[$];
    t_out   write_queue[$];
    logic [25:0] crystal_hz;
    logic [25:0] xtal_set[6];
    int     error_count;
    int     request_count;
    int     write_count;
    longint cycle_count;
    bit     idle_enable;
    bit     hold_receiver;
    int     long_hold;
    int     send_gap;
    int     recv_gap;
    bit     reset_done;
    logic   o_in_ready_seen;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [31:0] step_threshold(int i);
        logic [31:0] thr[36] = '{125000001, 87600000, 68000000, 55600000, 47100000,
            40800000, 36000000, 32300000, 29200000, 26700000, 24600000, 22700000,
            21200000, 19700000, 18600000, 17600000, 16300000, 14700000, 13100000,
            11600000, 10100000, 8520000, 6970000, 5430000, 3880000, 2340000, 797000,
            500000, 330000, 150000, 67000, 30300, 14000, 7000, 3500, 0};
        return thr[i];
    endfunction

    function automatic int step_divider(int i);
        int md[36] = '{4, 6, 8, 10, 12, 14, 16, 18, 20, 22, 24, 26, 28, 30, 32, 34, 36,
            40, 44, 50, 56, 66, 78, 98, 128, 190, 360, 800, 1280, 1300, 1500, 1600,
            1800, 1800, 1800, 1800};
        return md[i];
    endfunction

    function automatic int step_shift(int i);
        return (i < 29) ? 0 : i - 28;
    endfunction

    task automatic push_write(input logic [7:0] addr, input logic [63:0] data,
                              input bit fin);
        t_out w;
        w.reg_address = addr;
        w.reg_data    = data[7:0];
        w.last        = fin;
        write_queue.push_back(w);
    endtask

    task automatic predict_writes(input t_in req);
        logic [63:0] freq, vco, xtal, a, b, dd, p1, p2, p3, mp1;
        int md, rs;
        if (!req.enable) begin
            push_write(REG_ENABLE, 64'(VAL_OFF), 1'b1);
            return;
        end
        push_write(REG_ENABLE, 64'(VAL_ON), 1'b0);
        freq = 64'(req.freq_hz);
        if (freq < FREQ_MIN) freq = 64'(FREQ_MIN);
        else if (freq > FREQ_MAX) freq = 64'(FREQ_MAX);
        md = 1800;
        rs = 7;
        for (int i = 0; i < 36; i++) begin
            if (freq >= step_threshold(i)) begin
                md = step_divider(i);
                rs = step_shift(i);
                break;
            end
        end
        vco  = (freq * 64'(md)) << rs;
        xtal = (crystal_hz == 0) ? 64'd1 : 64'(crystal_hz);
        a    = vco / xtal;
        b    = ((vco - a * xtal) * 64'hFFFFF) / xtal;
        dd   = (64'd128 * b) / 64'hFFFFF;
        p1   = 64'd128 * a + dd - 64'd512;
        p2   = 64'd128 * b - 64'hFFFFF * dd;
        p3   = 64'hFFFFF;
        push_write(8'd34, p3 >> 8, 1'b0);
        push_write(8'd35, p3, 1'b0);
        push_write(8'd36, (p1 >> 16) & 64'h3, 1'b0);
        push_write(8'd37, p1 >> 8, 1'b0);
        push_write(8'd38, p1, 1'b0);
        push_write(8'd39, ((p3 >> 12) & 64'hF0) | ((p2 >> 16) & 64'h0F), 1'b0);
        push_write(8'd40, p2 >> 8, 1'b0);
        push_write(8'd41, p2, 1'b0);
        push_write(8'd50, 64'd0, 1'b0);
        push_write(8'd51, 64'd1, 1'b0);
        if (md == 4) begin
            push_write(8'd52, 64'h0C, 1'b0);
            push_write(8'd53, 64'd0, 1'b0);
            push_write(8'd54, 64'd0, 1'b0);
        end else begin
            mp1 = 64'(128 * md - 512);
            push_write(8'd52, ((64'(rs) << 4) & 64'h70) | ((mp1 >> 16) & 64'h3), 1'b0);
            push_write(8'd53, mp1 >> 8, 1'b0);
            push_write(8'd54, mp1, 1'b0);
        end
        push_write(8'd55, 64'd0, 1'b0);
        push_write(8'd56, 64'd0, 1'b0);
        push_write(8'd57, 64'd0, 1'b1);
    endtask

    // Driver: offers the next pending request once the previous one has been transferred.
    always @(negedge i_clk) begin
        if (reset_done) begin
            if (!i_in_valid || o_in_ready_seen) begin
                if (send_gap > 0) begin
                    send_gap   <= send_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (request_queue.size() > 0) begin
                    i_in       <= request_queue.pop_front();
                    i_in_valid <= 1'b1;
                    if (idle_enable && $urandom_range(0, 5) == 0)
                        send_gap <= $urandom_range(1, 14);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Input transfers are taken at the rising edge and fed to the predictor.
    always @(posedge i_clk) begin
        o_in_ready_seen <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            predict_writes(i_in);
            request_count <= request_count + 1;
        end
    end

    // Monitor: checks every output transfer against the oldest predicted write.
    always @(posedge i_clk) begin
        t_out want;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            write_count <= write_count + 1;
            if (write_queue.size() == 0) begin
                $error("unexpected write addr %0d data %0h", o_out.reg_address,
                       o_out.reg_data);
                error_count = error_count + 1;
            end else begin
                want = write_queue.pop_front();
                if (want.reg_address !== o_out.reg_address) begin
                    $error("reg_address expected %0d actual %0d", want.reg_address,
                           o_out.reg_address);
                    error_count = error_count + 1;
                end
                if (want.reg_data !== o_out.reg_data) begin
                    $error("reg_data expected %0h actual %0h", want.reg_data,
                           o_out.reg_data);
                    error_count = error_count + 1;
                end
                if (want.last !== o_out.last) begin
                    $error("last expected %0b actual %0b", want.last, o_out.last);
                    error_count = error_count + 1;
                end
            end
        end
    end

    // Receiver readiness with random stalls and one long hold-off.
    always @(negedge i_clk) begin
        if (long_hold > 0) begin
            long_hold   <= long_hold - 1;
            i_out_ready <= 1'b0;
        end else if (hold_receiver) begin
            i_out_ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap    <= recv_gap - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if (idle_enable && $urandom_range(0, 6) == 0)
                recv_gap <= $urandom_range(1, 14);
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("clock_synth_divider_calc regression: fail");
            $finish;
        end
    end

    function automatic t_in make_request(input logic [31:0] freq, input logic en);
        t_in r;
        r.freq_hz = freq;
        r.enable  = en;
        return r;
    endfunction

    function automatic logic [31:0] random_freq();
        int i;
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 3000);
            2: begin
                i = $urandom_range(0, 34);
                return step_threshold(i) + $urandom_range(0, 1) - 1;
            end
            default: return $urandom_range(1500, 280000000);
        endcase
    endfunction

    task automatic drain();
        while (request_queue.size() != 0 || i_in_valid) @(posedge i_clk);
        while (write_queue.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_crystal(input logic [25:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        crystal_hz = value;
    endtask

    task automatic random_phase(input int count);
        for (int k = 0; k < count; k++)
            request_queue.push_back(make_request(random_freq(),
                                                 $urandom_range(0, 7) != 0));
        drain();
    endtask

    initial begin
        xtal_set = '{26'd10000000, 26'd40000000, 26'd0, 26'h3FFFFFF,
                     26'd1, 26'd27000000};
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_in = '0;
        i_in_valid = 1'b0;
        i_out_ready = 1'b0;
        o_in_ready_seen = 1'b0;
        crystal_hz = 26'd25000000;
        error_count = 0;
        request_count = 0;
        write_count = 0;
        cycle_count = 0;
        idle_enable = 1'b1;
        hold_receiver = 1'b0;
        long_hold = 0;
        send_gap = 0;
        recv_gap = 0;
        reset_done = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        reset_done = 1'b1;

        request_queue.push_back(make_request(32'd0, 1'b1));
        request_queue.push_back(make_request(32'd1499, 1'b1));
        request_queue.push_back(make_request(32'd1500, 1'b1));
        request_queue.push_back(make_request(32'd3499, 1'b1));
        request_queue.push_back(make_request(32'd150000, 1'b1));
        request_queue.push_back(make_request(32'd125000000, 1'b1));
        request_queue.push_back(make_request(32'd125000001, 1'b1));
        request_queue.push_back(make_request(32'd280000000, 1'b1));
        request_queue.push_back(make_request(32'd280000001, 1'b1));
        request_queue.push_back(make_request(32'hFFFFFFFF, 1'b1));
        request_queue.push_back(make_request(32'hFFFFFFFF, 1'b0));
        request_queue.push_back(make_request(32'd0, 1'b0));
        request_queue.push_back(make_request(32'hAAAAAAAA, 1'b1));
        request_queue.push_back(make_request(32'h55555555, 1'b1));
        drain();

        foreach (xtal_set[k]) begin
            write_crystal(xtal_set[k]);
            random_phase(20);
        end
        write_crystal(26'd25000000);

        long_hold = 600;
        random_phase(15);

        for (int k = 0; k < 4; k++) begin
            write_crystal(26'($urandom_range(10000000, 40000000)));
            random_phase(40);
        end
        idle_enable = 1'b0;
        random_phase(60);

        $display("%0d requests and %0d register writes checked over several crystal settings",
                 request_count, write_count);
        if (error_count == 0) begin
            $display("clock_synth_divider_calc regression: pass");
        end else begin
            $display("clock_synth_divider_calc regression: fail");
        end
        $finish;
    end

endmodule
